// ===== design/pirbc_pkg.sv =====
// Package for the PI regulator with back-calculation anti-windup.
// Widths, register indexes, reset values and saturation helpers.
// No dependencies.
`default_nettype none

package pirbc_pkg;

    localparam int DATA_W  = 32;               // Q16.16 word
    localparam int RATIO_W = 17;               // Q1.16 step ratio, 1.0 included
    localparam int FRAC_W  = 16;
    localparam int SUM_W   = DATA_W + 3;       // room for exact sums and differences
    localparam int HI_W    = DATA_W + 1;       // upper half of the shift-add product
    localparam int ADD_W   = DATA_W + 2;       // adder of one multiply step
    localparam int CNT_W   = $clog2(DATA_W);
    localparam int CFG_IDX_W = 3;

    localparam int MUL1_STEPS = DATA_W;
    localparam int MUL2_STEPS = RATIO_W;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT  = 3'd4;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [RATIO_W-1:0]       Q_ONE   = {1'b1, {(RATIO_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] GAIN_KP_RST = 32'sh0001_0000;

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic signed [DATA_W-1:0] v);
        sext_sum = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // saturate an exact sum to the signed word range
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}})
            sat_sum = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            sat_sum = S32_MIN;
        else
            sat_sum = S32_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== design/pi_regulator_back_calculation_top.sv =====
// PI regulator, back-calculation anti-windup, signed Q16.16.
// Inputs are accepted only in idle, so one transaction is processed at a time;
// a result waits in the clamp state until the output register is free.
// Radix-2 shift-add multiplier: 32 steps for gain * error, 17 for prop * ratio.
// Reset: asynchronous, active low; registers take their reset values, integrator 0.
// Depends on pirbc_pkg.
`default_nettype none

module pi_regulator_back_calculation_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] reference, [63:32] feedback
    input  wire logic [1:0]  s_tuser,   // [0] preset_flag, [1] clear_flag
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] drive_out, [63:32] integral_value
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pirbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pirbc_pkg::DATA_W-1:0]    cfg_data
);

    localparam int DW = pirbc_pkg::DATA_W;
    localparam int RW = pirbc_pkg::RATIO_W;
    localparam int HW = pirbc_pkg::HI_W;
    localparam int AW = pirbc_pkg::ADD_W;
    localparam int SW = pirbc_pkg::SUM_W;
    localparam int CW = pirbc_pkg::CNT_W;
    localparam int FW = pirbc_pkg::FRAC_W;
    localparam int PW = HW + DW - FW;   // product shifted right by the fraction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL1,
        ST_PROP,
        ST_MUL2,
        ST_INTEG,
        ST_SUM,
        ST_CLAMP
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic signed [DW-1:0] gain_kp_reg, gain_kp_next;
    logic [RW-1:0]        step_ratio_reg, step_ratio_next;
    logic signed [DW-1:0] preset_value_reg, preset_value_next;
    logic signed [DW-1:0] upper_limit_reg, upper_limit_next;
    logic signed [DW-1:0] lower_limit_reg, lower_limit_next;

    logic signed [DW-1:0] ref_reg, ref_next;
    logic signed [DW-1:0] fbk_reg, fbk_next;
    logic                 preset_reg, preset_next;
    logic                 clear_reg, clear_next;

    logic signed [DW-1:0] mcand_reg, mcand_next;
    logic signed [HW-1:0] hi_reg, hi_next;
    logic [DW-1:0]        lo_reg, lo_next;

    logic signed [DW-1:0] prop_reg, prop_next;
    logic signed [DW-1:0] integ_reg, integ_next;
    logic signed [DW-1:0] y_reg, y_next;

    logic signed [DW-1:0] drive_reg, drive_next;
    logic signed [DW-1:0] integ_out_reg, integ_out_next;
    logic                 out_valid_reg, out_valid_next;

    // multiply step and datapath helpers
    logic signed [AW-1:0] mcand_ext;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] step_sum;
    logic                 sign_step;
    logic signed [DW-1:0] err_sat;
    logic [PW-1:0]        prod_shr;
    logic signed [DW-1:0] prop_sat;
    logic signed [SW-1:0] inc_ext;
    logic [RW-1:0]        ratio_lim;
    logic signed [DW-1:0] limit_sel;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {integ_out_reg, drive_reg};

    always_comb
    begin
        // one bit of the multiplier per cycle; the sign bit of a signed
        // multiplier is weighted negative, so the last gain step subtracts
        sign_step = (state_reg == ST_MUL1) && (cnt_reg == CW'(pirbc_pkg::MUL1_STEPS - 1));
        mcand_ext = {{(AW-DW){mcand_reg[DW-1]}}, mcand_reg};
        if (!lo_reg[0])
            addend = '0;
        else if (sign_step)
            addend = -mcand_ext;
        else
            addend = mcand_ext;
        step_sum = {hi_reg[HW-1], hi_reg} + addend;

        err_sat = pirbc_pkg::sat_sum(pirbc_pkg::sext_sum(ref_reg) - pirbc_pkg::sext_sum(fbk_reg));

        // floor shift of the full product is an arithmetic shift
        prod_shr = {hi_reg, lo_reg[DW-1:FW]};
        if (prod_shr[PW-1:DW-1] == {(PW-DW+1){prod_shr[PW-1]}})
            prop_sat = prod_shr[DW-1:0];
        else if (prod_shr[PW-1])
            prop_sat = pirbc_pkg::S32_MIN;
        else
            prop_sat = pirbc_pkg::S32_MAX;

        // after the ratio steps, product bit FW sits in lo_reg[DW-1]
        inc_ext = {hi_reg[HW-1], hi_reg, lo_reg[DW-1]};

        ratio_lim = (step_ratio_reg > pirbc_pkg::Q_ONE) ? pirbc_pkg::Q_ONE : step_ratio_reg;

        limit_sel = (y_reg <= lower_limit_reg) ? lower_limit_reg : upper_limit_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        gain_kp_next      = gain_kp_reg;
        step_ratio_next   = step_ratio_reg;
        preset_value_next = preset_value_reg;
        upper_limit_next  = upper_limit_reg;
        lower_limit_next  = lower_limit_reg;
        ref_next          = ref_reg;
        fbk_next          = fbk_reg;
        preset_next       = preset_reg;
        clear_next        = clear_reg;
        mcand_next        = mcand_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        prop_next         = prop_reg;
        integ_next        = integ_reg;
        y_next            = y_reg;
        drive_next        = drive_reg;
        integ_out_next    = integ_out_reg;
        out_valid_next    = out_valid_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                pirbc_pkg::REG_GAIN_KP:      gain_kp_next      = cfg_data;
                pirbc_pkg::REG_STEP_RATIO:   step_ratio_next   = cfg_data[RW-1:0];
                pirbc_pkg::REG_PRESET_VALUE: preset_value_next = cfg_data;
                pirbc_pkg::REG_UPPER_LIMIT:  upper_limit_next  = cfg_data;
                pirbc_pkg::REG_LOWER_LIMIT:  lower_limit_next  = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ref_next    = s_tdata[DW-1:0];
                    fbk_next    = s_tdata[2*DW-1:DW];
                    preset_next = s_tuser[0];
                    clear_next  = s_tuser[1];
                    state_next  = ST_ERR;
                end
            end
            ST_ERR:
            begin
                mcand_next = gain_kp_reg;
                hi_next    = '0;
                lo_next    = err_sat;
                cnt_next   = '0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                hi_next  = step_sum[AW-1:1];
                lo_next  = {step_sum[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(pirbc_pkg::MUL1_STEPS - 1))
                    state_next = ST_PROP;
            end
            ST_PROP:
            begin
                prop_next  = clear_reg ? '0 : prop_sat;
                mcand_next = prop_sat;
                hi_next    = '0;
                lo_next    = {{(DW-RW){1'b0}}, ratio_lim};
                cnt_next   = '0;
                state_next = (clear_reg || preset_reg) ? ST_INTEG : ST_MUL2;
            end
            ST_MUL2:
            begin
                hi_next  = step_sum[AW-1:1];
                lo_next  = {step_sum[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(pirbc_pkg::MUL2_STEPS - 1))
                    state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                priority if (clear_reg)
                    integ_next = '0;
                else if (preset_reg)
                    integ_next = pirbc_pkg::sat_sum(pirbc_pkg::sext_sum(preset_value_reg)
                                                    - pirbc_pkg::sext_sum(prop_reg));
                else
                    integ_next = pirbc_pkg::sat_sum(pirbc_pkg::sext_sum(integ_reg) + inc_ext);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                y_next = pirbc_pkg::sat_sum(pirbc_pkg::sext_sum(prop_reg)
                                            + pirbc_pkg::sext_sum(integ_reg));
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    priority if (upper_limit_reg < lower_limit_reg)
                    begin
                        drive_next     = '0;
                        integ_out_next = integ_reg;
                    end
                    else if ((y_reg <= lower_limit_reg) || (y_reg >= upper_limit_reg))
                    begin
                        // back-calculate the integrator onto the active limit
                        drive_next     = limit_sel;
                        integ_next     = pirbc_pkg::sat_sum(pirbc_pkg::sext_sum(limit_sel)
                                                            - pirbc_pkg::sext_sum(prop_reg));
                        integ_out_next = integ_next;
                    end
                    else
                    begin
                        drive_next     = y_reg;
                        integ_out_next = integ_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            gain_kp_reg      <= pirbc_pkg::GAIN_KP_RST;
            step_ratio_reg   <= '0;
            preset_value_reg <= '0;
            upper_limit_reg  <= pirbc_pkg::S32_MAX;
            lower_limit_reg  <= pirbc_pkg::S32_MIN;
            ref_reg          <= '0;
            fbk_reg          <= '0;
            preset_reg       <= 1'b0;
            clear_reg        <= 1'b0;
            mcand_reg        <= '0;
            hi_reg           <= '0;
            lo_reg           <= '0;
            prop_reg         <= '0;
            integ_reg        <= '0;
            y_reg            <= '0;
            drive_reg        <= '0;
            integ_out_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            gain_kp_reg      <= gain_kp_next;
            step_ratio_reg   <= step_ratio_next;
            preset_value_reg <= preset_value_next;
            upper_limit_reg  <= upper_limit_next;
            lower_limit_reg  <= lower_limit_next;
            ref_reg          <= ref_next;
            fbk_reg          <= fbk_next;
            preset_reg       <= preset_next;
            clear_reg        <= clear_next;
            mcand_reg        <= mcand_next;
            hi_reg           <= hi_next;
            lo_reg           <= lo_next;
            prop_reg         <= prop_next;
            integ_reg        <= integ_next;
            y_reg            <= y_next;
            drive_reg        <= drive_next;
            integ_out_reg    <= integ_out_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/pirbc_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the PI regulator testbench: bit-exact model of one control
// tick plus the queue of outputs still owed by the block. Depends on pirbc_pkg.

package pirbc_tb_pkg;

    import pirbc_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] integ;
        logic signed [DATA_W-1:0] drive;
    } pi_output_t;

    class pirbc_scoreboard;

        logic signed [DATA_W-1:0] kp;
        logic [RATIO_W-1:0]       ratio;
        logic signed [DATA_W-1:0] preset;
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] integ;
        pi_output_t               pending_outputs[$];
        int                       errors;
        int                       outputs_seen;

        function new();
            kp           = GAIN_KP_RST;
            ratio        = '0;
            preset       = '0;
            upper        = S32_MAX;
            lower        = S32_MIN;
            integ        = '0;
            errors       = 0;
            outputs_seen = 0;
        endfunction

        static function longint clip(longint v);
            if (v > longint'(S32_MAX))
                return longint'(S32_MAX);
            if (v < longint'(S32_MIN))
                return longint'(S32_MIN);
            return v;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
            case (idx)
                REG_GAIN_KP:      kp     = d;
                REG_STEP_RATIO:   ratio  = d[RATIO_W-1:0];
                REG_PRESET_VALUE: preset = d;
                REG_UPPER_LIMIT:  upper  = d;
                REG_LOWER_LIMIT:  lower  = d;
                default: ;        // unmapped index, write dropped
            endcase
        endfunction

        // one control tick: proportional part, integrator update, clamp
        function void note_sample(logic signed [DATA_W-1:0] target,
                                  logic signed [DATA_W-1:0] measured,
                                  logic preset_flag, logic clear_flag);
            longint     err;
            longint     prop;
            longint     eff_ratio;
            longint     acc;
            longint     y;
            pi_output_t out;
            err       = clip(longint'(target) - longint'(measured));
            prop      = clip((longint'(kp) * err) >>> FRAC_W);
            eff_ratio = (ratio > Q_ONE) ? longint'(Q_ONE) : longint'(ratio);
            acc       = longint'(integ);
            if (clear_flag)
            begin
                prop = 0;
                acc  = 0;
            end
            else if (preset_flag)
            begin
                acc = clip(longint'(preset) - prop);
            end
            else
            begin
                acc = clip(acc + ((prop * eff_ratio) >>> FRAC_W));
            end
            y = clip(prop + acc);
            if (upper < lower)
            begin
                y = 0;
            end
            else if (y <= longint'(lower))
            begin
                y   = longint'(lower);
                acc = clip(y - prop);
            end
            else if (y >= longint'(upper))
            begin
                y   = longint'(upper);
                acc = clip(y - prop);
            end
            integ     = acc[DATA_W-1:0];
            out.drive = y[DATA_W-1:0];
            out.integ = integ;
            pending_outputs.push_back(out);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_output(logic [2*DATA_W-1:0] d);
            pi_output_t want;
            outputs_seen++;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("output %0d arrived with nothing pending, data %h",
                                 outputs_seen, d));
                return;
            end
            want = pending_outputs.pop_front();
            if (d[DATA_W-1:0] !== want.drive)
                report($sformatf("output %0d drive_out %h, predicted %h",
                                 outputs_seen, d[DATA_W-1:0], want.drive));
            if (d[2*DATA_W-1:DATA_W] !== want.integ)
                report($sformatf("output %0d integral_value %h, predicted %h",
                                 outputs_seen, d[2*DATA_W-1:DATA_W], want.integ));
        endtask

        task check_drained();
            if (pending_outputs.size() != 0)
                report($sformatf("%0d outputs never arrived", pending_outputs.size()));
        endtask

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for pi_regulator_back_calculation_top: directed and random
// control ticks under changing register settings, with bursty input and a
// stalling output side. Depends on pirbc_pkg and pirbc_tb_pkg.

module tb_top;

    import pirbc_pkg::*;
    import pirbc_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_TICKS   = 900;
    localparam int DRAIN_CYCLES   = 60;

    localparam logic signed [DATA_W-1:0] Q_UNIT = 32'sh0001_0000;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_BLOCKS} ready_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [2*DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [2*DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    pirbc_scoreboard sb;

    int          idle_cycles = 0;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          mode_left   = 0;
    int          hold_left   = 0;
    int          pat_cnt     = 0;

    pi_regulator_back_calculation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: stall pattern switches to a new random mode when the current one runs out
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        pat_cnt++;
        case (ready_mode)
            RDY_ALWAYS:   m_tready = 1'b1;
            RDY_COIN:     m_tready = $urandom_range(0, 1);
            RDY_PERIODIC: m_tready = (pat_cnt % 6) != 0;
            default:
            begin
                if (hold_left == 0)
                begin
                    m_tready  = !m_tready;
                    hold_left = m_tready ? $urandom_range(1, 30) : $urandom_range(1, 24);
                end
                hold_left--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // all driving tasks start and end at a falling edge
    task automatic send_tick(input logic [DATA_W-1:0] target, input logic [DATA_W-1:0] measured,
                             input logic preset_flag, input logic clear_flag);
        s_tdata  = {measured, target};
        s_tuser  = {clear_flag, preset_flag};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(target, measured, preset_flag, clear_flag);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
        cfg_index = idx;
        cfg_data  = d;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apply_config(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ratio,
                                input logic [DATA_W-1:0] preset, input logic [DATA_W-1:0] upper,
                                input logic [DATA_W-1:0] lower, input bit poke_unmapped);
        int j;
        wait_drained();
        write_cfg(REG_GAIN_KP, kp);
        write_cfg(REG_STEP_RATIO, ratio);
        write_cfg(REG_PRESET_VALUE, preset);
        write_cfg(REG_UPPER_LIMIT, upper);
        write_cfg(REG_LOWER_LIMIT, lower);
        // unmapped indexes must not alias onto real registers
        if (poke_unmapped)
            for (j = int'(REG_LOWER_LIMIT) + 1; j < (1 << CFG_IDX_W); j++)
                write_cfg(j[CFG_IDX_W-1:0], $urandom_range(0, 1) ? '0 : $urandom);
    endtask

    function automatic logic [DATA_W-1:0] pick_signal();
        case ($urandom_range(0, 19))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
        endcase
    endfunction

    task automatic random_config();
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] ratio;
        logic [DATA_W-1:0] preset;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] tmp;
        case ($urandom_range(0, 9))
            0:       kp = S32_MAX;
            1:       kp = S32_MIN;
            2:       kp = $urandom;
            3:       kp = '0;
            default: kp = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        case ($urandom_range(0, 7))
            0:       ratio = '0;
            1:       ratio = Q_ONE;
            2:       ratio = $urandom_range(int'(Q_ONE) + 1, (1 << RATIO_W) - 1);
            3:       ratio = (1 << RATIO_W) - 1;
            default: ratio = $urandom_range(0, int'(Q_ONE));
        endcase
        // junk above the ratio field now and then
        if ($urandom_range(0, 3) == 0)
            ratio[DATA_W-1:RATIO_W] = $urandom;
        case ($urandom_range(0, 7))
            0:       preset = S32_MAX;
            1:       preset = S32_MIN;
            2:       preset = $urandom;
            default: preset = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        endcase
        case ($urandom_range(0, 9))
            0:
            begin
                upper = S32_MAX;
                lower = S32_MIN;
            end
            1:
            begin
                lower = $urandom_range(0, 32'h0064_0000);
                upper = -$urandom_range(1, 32'h0064_0000);
            end
            2:
            begin
                upper = pick_signal();
                lower = upper;
            end
            3:
            begin
                upper = $urandom;
                lower = $urandom;
            end
            default:
            begin
                upper = $urandom_range(0, 32'h00C8_0000);
                lower = -$urandom_range(0, 32'h00C8_0000);
            end
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            tmp   = upper;
            upper = lower;
            lower = tmp;
        end
        apply_config(kp, ratio, preset, upper, lower, $urandom_range(0, 3) == 0);
    endtask

    task automatic directed_ticks();
        // defaults: unity gain, no integral action, full-range limits
        send_tick('0, '0, 1'b0, 1'b0);
        send_tick(S32_MAX, S32_MIN, 1'b0, 1'b0);
        send_tick(S32_MIN, S32_MAX, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFFF, '0, 1'b0, 1'b0);
        send_tick(5 * Q_UNIT, Q_UNIT, 1'b1, 1'b0);
        send_tick(3 * Q_UNIT, '0, 1'b1, 1'b1);
        send_tick(7 * Q_UNIT, '0, 1'b0, 1'b1);
        // most negative gain, ratio above one, clamps at +/-100
        apply_config(S32_MIN, (1 << RATIO_W) - 1, S32_MAX, 100 * Q_UNIT, -100 * Q_UNIT, 1'b1);
        send_tick(32'd1, '0, 1'b0, 1'b0);
        send_tick(Q_UNIT, '0, 1'b0, 1'b0);
        send_tick(S32_MAX, S32_MIN, 1'b0, 1'b0);
        send_tick('0, '0, 1'b1, 1'b0);
        send_tick(S32_MIN, S32_MIN, 1'b0, 1'b0);
        // landing exactly on a limit still back-calculates
        apply_config(Q_UNIT, '0, '0, 5 * Q_UNIT, -5 * Q_UNIT, 1'b0);
        send_tick('0, '0, 1'b0, 1'b1);
        send_tick(5 * Q_UNIT, '0, 1'b0, 1'b0);
        send_tick(-5 * Q_UNIT, '0, 1'b0, 1'b0);
        send_tick(4 * Q_UNIT, '0, 1'b0, 1'b0);
        // crossed limits force zero output
        apply_config(Q_UNIT, Q_ONE, 2 * Q_UNIT, -Q_UNIT, Q_UNIT, 1'b0);
        send_tick(3 * Q_UNIT, '0, 1'b0, 1'b0);
        send_tick('0, '0, 1'b1, 1'b0);
        send_tick(S32_MAX, S32_MIN, 1'b0, 1'b0);
        // largest gain, both limits at the top of the range
        apply_config(S32_MAX, Q_ONE, S32_MIN, S32_MAX, S32_MAX, 1'b0);
        send_tick('0, '0, 1'b0, 1'b0);
        send_tick(S32_MIN, S32_MAX, 1'b0, 1'b0);
    endtask

    task automatic random_ticks();
        int  sent;
        int  n;
        int  k;
        int  burst_left;
        int  hold_at;
        bit  no_idle;
        bit  first_phase;
        sent        = 0;
        burst_left  = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_TICKS)
        begin
            random_config();
            n       = $urandom_range(60, 140);
            no_idle = $urandom_range(0, 3) == 0;
            hold_at = first_phase ? n / 2
                                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, n) : -1);
            for (k = 0; k < n; k++)
            begin
                if (k == hold_at)
                    wait_drained();
                if (burst_left == 0)
                begin
                    if (!no_idle)
                    begin
                        s_tvalid = 1'b0;
                        repeat ($urandom_range(1, 40)) @(negedge clk);
                    end
                    burst_left = $urandom_range(1, 8);
                end
                send_tick(pick_signal(), pick_signal(),
                          $urandom_range(0, 11) == 0, $urandom_range(0, 19) == 0);
                burst_left--;
            end
            sent += n;
            first_phase = 1'b0;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed_ticks();
        random_ticks();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pirbc_pkg.sv
design/pi_regulator_back_calculation_top.sv
dv/pirbc_tb_pkg.sv
dv/tb_top.sv
